/* rtl/fwp_pkg.sv */
// ----------------------------------------------------------------------------
// fwp_pkg
// Shared widths, defaults and the label cancellation test for the foldable
// word pairing block.
// ----------------------------------------------------------------------------
`default_nettype none

package fwp_pkg;

  localparam int LABEL_W         = 8;
  localparam int ROW_POS_W       = 6;
  localparam int MASK_W          = 64;
  localparam int MAX_LEN_DEFAULT = 64;

  // Two labels cancel when their signed sum is zero; -128 never cancels.
  function automatic logic labels_cancel(input logic [LABEL_W-1:0] a,
                                         input logic [LABEL_W-1:0] b);
    logic [LABEL_W:0] sum;
    sum = {a[LABEL_W-1], a} + {b[LABEL_W-1], b};
    return (sum == '0);
  endfunction

endpackage

`default_nettype wire

/* rtl/fwp_label_mem.sv */
// ----------------------------------------------------------------------------
// fwp_label_mem
// Label store of the current word with two registered read ports and the
// shared cancellation compare on the pair that was read.
// ----------------------------------------------------------------------------
`default_nettype none

module fwp_label_mem #(
  parameter int MAX_LEN = fwp_pkg::MAX_LEN_DEFAULT,
  parameter int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [fwp_pkg::LABEL_W-1:0] wr_data,
  input  wire logic [AW-1:0]              rd_addr_a,
  input  wire logic [AW-1:0]              rd_addr_b,
  output logic                            pair_cancel
);

  logic [fwp_pkg::LABEL_W-1:0] mem [MAX_LEN];
  logic [fwp_pkg::LABEL_W-1:0] rd_a;
  logic [fwp_pkg::LABEL_W-1:0] rd_b;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

  assign pair_cancel = fwp_pkg::labels_cancel(rd_a, rd_b);

endmodule

`default_nettype wire

/* rtl/foldable_word_pairing_top.sv */
// ----------------------------------------------------------------------------
// foldable_word_pairing_top
// Collects a word of signed labels, checks that it cancels to empty, fills
// the foldable sub-word table and lists the fold partners of each position but the last.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transaction per letter,
//   label_value plus last_letter. Letters past MAX_LEN are dropped and flag
//   length_overflow for that word. in_stall is low only while collecting.
//   Output channel (out_valid / out_stall): after the last letter the block
//   returns one transaction for a word that does not cancel (or has one
//   letter), else n-1 transactions, rows 0 to n-2 in order, with last_row
//   high on the final one. Results sit in output registers until taken; a
//   stall just holds them and the sequencer waits.
//   Order of work for a word of n letters: the letters are collected; then
//   the cancellation stack runs (one label compare per letter, with a stack
//   read, label read and update step for each), the table rows are cleared,
//   the table fill runs one interval step at a time, limited by the single
//   label compare and the two-port table row reads, and the results go out
//   one by one as the receiver takes them.
//   Reset: synchronous, returns to collecting with an empty word and no
//   result pending; the stores hold no reset value; the table stores are cleared per word.
// ----------------------------------------------------------------------------
`default_nettype none

module foldable_word_pairing_top #(
  parameter int MAX_LEN = fwp_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [fwp_pkg::LABEL_W-1:0] label_value,
  input  wire logic                               last_letter,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [fwp_pkg::ROW_POS_W-1:0]           row_position,
  output logic [fwp_pkg::MASK_W-1:0]              partner_mask,
  output logic                                    word_foldable,
  output logic                                    length_overflow,
  output logic                                    last_row
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);

  typedef enum logic [3:0] {
    S_COLLECT,
    S_STK_A,
    S_STK_B,
    S_STK_C,
    S_STK_DONE,
    S_CLEAR,
    S_DP_A,
    S_DP_B,
    S_DP_C,
    S_EMIT_RD,
    S_EMIT_LD,
    S_FAIL,
    S_OUT
  } state_t;

  state_t state;

  // Word collection
  logic [LW-1:0] wlen;
  logic          ovf;
  logic [LW-1:0] n;
  logic          word_ovf;
  logic [LW-1:0] wlen_next;
  logic          ovf_next;
  logic          in_accept;
  logic          store_letter;

  // Sequencer counters
  logic [AW-1:0] pos;
  logic [LW-1:0] depth;
  logic [LW-1:0] k;
  logic [AW-1:0] i;
  logic [LW:0]   j_sum;
  logic [AW-1:0] j_idx;
  logic [LW:0]   k_plus2;

  // Stores
  logic [AW-1:0]      stk [MAX_LEN];
  logic [AW-1:0]      stk_rd;
  logic [MAX_LEN-1:0] tbl [MAX_LEN];
  logic [MAX_LEN-1:0] tbl_rd_a;
  logic [MAX_LEN-1:0] tbl_rd_b;
  logic [MAX_LEN-1:0] pair [MAX_LEN];
  logic [MAX_LEN-1:0] pair_rd;
  logic [AW-1:0]      lp [MAX_LEN];
  logic [AW-1:0]      lp_rd;

  logic          pair_cancel;
  logic [AW-1:0] lbl_addr_a;
  logic [AW-1:0] lbl_addr_b;
  logic          stk_phase;
  logic          wrap;
  logic          split;
  logic          dp_set;

  assign in_stall  = (state != S_COLLECT);
  assign in_accept = in_valid && !in_stall;

  // Letter store: drop letters once the word is full, flag the overflow.
  assign store_letter = (wlen < LW'(MAX_LEN));

  always_comb begin
    if (store_letter) begin
      wlen_next = wlen + 1'b1;
      ovf_next  = ovf;
    end else begin
      wlen_next = wlen;
      ovf_next  = 1'b1;
    end
  end

  // Interval indices: j = i + k, widened so the end test cannot wrap.
  assign j_sum   = (LW+1)'(i) + (LW+1)'(k);
  assign j_idx   = j_sum[AW-1:0];
  assign k_plus2 = (LW+1)'(k) + (LW+1)'(2);

  // Label compare unit is shared by the stack check and the table fill.
  assign stk_phase  = (state == S_STK_A) || (state == S_STK_B) || (state == S_STK_C);
  assign lbl_addr_a = stk_phase ? stk_rd : i;
  assign lbl_addr_b = stk_phase ? pos : j_idx;

  fwp_label_mem #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW)
  ) u_label_mem (
    .clk         (clk),
    .wr_en       (in_accept && store_letter),
    .wr_addr     (wlen[AW-1:0]),
    .wr_data     (label_value),
    .rd_addr_a   (lbl_addr_a),
    .rd_addr_b   (lbl_addr_b),
    .pair_cancel (pair_cancel)
  );

  // Sub-word [i, j] folds by wrapping (ends cancel around a foldable inside)
  // or by splitting after the latest partner of i found so far.
  assign wrap   = pair_cancel && ((k == LW'(1)) || tbl_rd_a[j_idx - 1'b1]);
  assign split  = (lp_rd != '0) && tbl_rd_b[j_idx];
  assign dp_set = (state == S_DP_C) && (wrap || split);

  // Cancellation stack: read the top, push on no cancel.
  always_ff @(posedge clk) begin
    if ((state == S_STK_C) && !((depth != '0) && pair_cancel)) begin
      stk[depth[AW-1:0]] <= pos;
    end
    stk_rd <= stk[AW'(depth - 1'b1)];
  end

  // Foldable table, pairing table and latest partner per row.
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      tbl[pos]  <= '0;
      pair[pos] <= '0;
      lp[pos]   <= '0;
    end else if (dp_set) begin
      tbl[i][j_idx]  <= 1'b1;
      pair[i][j_idx] <= pair_cancel;
      lp[i]          <= j_idx;
    end
    tbl_rd_a <= tbl[i + 1'b1];
    tbl_rd_b <= tbl[lp_rd + 1'b1];
    pair_rd  <= pair[pos];
    lp_rd    <= lp[i];
  end

  // Sequencer and output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_COLLECT;
      wlen      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_COLLECT: begin
          if (in_accept) begin
            if (last_letter) begin
              n        <= wlen_next;
              word_ovf <= ovf_next;
              wlen     <= '0;
              ovf      <= 1'b0;
              pos      <= '0;
              depth    <= '0;
              if (wlen_next < LW'(2)) begin
                state <= S_FAIL;
              end else begin
                state <= S_STK_A;
              end
            end else begin
              wlen <= wlen_next;
              ovf  <= ovf_next;
            end
          end
        end
        S_STK_A: begin
          state <= S_STK_B;
        end
        S_STK_B: begin
          state <= S_STK_C;
        end
        S_STK_C: begin
          if ((depth != '0) && pair_cancel) begin
            depth <= depth - 1'b1;
          end else begin
            depth <= depth + 1'b1;
          end
          if (LW'(pos) + 1'b1 == n) begin
            state <= S_STK_DONE;
          end else begin
            pos   <= pos + 1'b1;
            state <= S_STK_A;
          end
        end
        S_STK_DONE: begin
          pos <= '0;
          if (depth == '0) begin
            state <= S_CLEAR;
          end else begin
            state <= S_FAIL;
          end
        end
        S_CLEAR: begin
          if (LW'(pos) + 1'b1 == n) begin
            k     <= LW'(1);
            i     <= '0;
            state <= S_DP_A;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        S_DP_A: begin
          state <= S_DP_B;
        end
        S_DP_B: begin
          state <= S_DP_C;
        end
        S_DP_C: begin
          // Advance along the diagonal, then to the next odd distance.
          if (j_sum + 1'b1 < (LW+1)'(n)) begin
            i     <= i + 1'b1;
            state <= S_DP_A;
          end else if (k_plus2 < (LW+1)'(n)) begin
            k     <= k_plus2[LW-1:0];
            i     <= '0;
            state <= S_DP_A;
          end else begin
            pos   <= '0;
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          row_position    <= fwp_pkg::ROW_POS_W'(pos);
          partner_mask    <= fwp_pkg::MASK_W'(pair_rd);
          word_foldable   <= 1'b1;
          length_overflow <= word_ovf;
          last_row        <= ((LW+1)'(pos) + (LW+1)'(2) == (LW+1)'(n));
          out_valid       <= 1'b1;
          state           <= S_OUT;
        end
        S_FAIL: begin
          row_position    <= '0;
          partner_mask    <= '0;
          word_foldable   <= 1'b0;
          length_overflow <= word_ovf;
          last_row        <= 1'b1;
          out_valid       <= 1'b1;
          state           <= S_OUT;
        end
        S_OUT: begin
          // Hold the result until the receiver takes it.
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_row) begin
              state <= S_COLLECT;
            end else begin
              pos   <= pos + 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state     <= S_COLLECT;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
